// File: rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// Shared constants, sine table and controller/datapath interface types for
// the button-to-analog-stick converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bts_pkg;

  localparam int TRIG_TABLE_BITS = 10;
  localparam int TRIG_QTR        = 1 << (TRIG_TABLE_BITS - 2);
  localparam int TRIG_KW         = TRIG_TABLE_BITS - 1;

  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 2;

  localparam logic CMD_EVENT = 1'b0;
  localparam logic CMD_POLL  = 1'b1;

  localparam logic [2:0] BTN_MOD = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MOD_SCALE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_RATE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ANALOG    = 2'd2;

  localparam logic [14:0] FULL_AMP      = 15'd32766;
  localparam logic [14:0] RST_MOD_SCALE = 15'd16384;
  localparam logic [19:0] RST_SLEW_RATE = 20'd57368;
  localparam logic [31:0] SNAP_MS       = 32'd10;
  localparam logic [31:0] MAX_DT_MS     = 32'd500;

  localparam longint ONE_Q30 = 64'sd1073741824;

  typedef logic [14:0] qsin_tab_t [0:TRIG_QTR];

  // sin(k / Q * quarter turn) scaled to 32767
  function automatic longint quarter_sine(input int k);
    longint z;
    longint z2;
    longint p;
    longint s;
    z  = (longint'(k) << (16 - TRIG_TABLE_BITS)) * 64'sd65536;
    z2 = z * z / ONE_Q30;
    p  = -64'sd3864;
    p  = 64'sd172272 + p * z2 / ONE_Q30;
    p  = -64'sd5026997 + p * z2 / ONE_Q30;
    p  = 64'sd85569306 + p * z2 / ONE_Q30;
    p  = -64'sd693598669 + p * z2 / ONE_Q30;
    p  = 64'sd1686629713 + p * z2 / ONE_Q30;
    s  = p * z / ONE_Q30;
    if (s < 0) begin
      s = 0;
    end
    if (s > ONE_Q30) begin
      s = ONE_Q30;
    end
    return (s * 64'sd32767 + ONE_Q30 / 2) / ONE_Q30;
  endfunction

  function automatic qsin_tab_t gen_qsin();
    qsin_tab_t t;
    for (int i = 0; i <= TRIG_QTR; i++) begin
      t[i] = 15'(quarter_sine(i));
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN_TAB = gen_qsin();

  typedef struct packed {
    logic latch;      // capture input word
    logic dt;         // elapsed time, button/modifier update
    logic mul1;       // rate * ms
    logic mul2;       // divide by 1000
    logic upd_angle;  // event: move current/goal angle
    logic calc_ang;   // angle used for the position
    logic zero_step;
    logic look;       // trig table read
    logic mult;       // amplitude * trig
    logic scale;      // divide by 32767
    logic use_cos;
    logic emit;       // load output word
  } bts_cmd_t;

  typedef struct packed {
    logic is_poll;
    logic drop;
    logic unchanged;
    logic out_free;
  } bts_sts_t;

endpackage

// File: rtl/bts_ctrl.sv
// ----------------------------------------------------------------------------
// bts_ctrl
// Sequencer: steps one word through time, slew, trig and scaling phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bts_pkg::bts_sts_t sts_i,
  output bts_pkg::bts_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_DT   = 4'd1;
  localparam logic [3:0] ST_MUL1 = 4'd2;
  localparam logic [3:0] ST_MUL2 = 4'd3;
  localparam logic [3:0] ST_SLEW = 4'd4;
  localparam logic [3:0] ST_ANG  = 4'd5;
  localparam logic [3:0] ST_LKS  = 4'd6;
  localparam logic [3:0] ST_MLS  = 4'd7;
  localparam logic [3:0] ST_SCS  = 4'd8;
  localparam logic [3:0] ST_LKC  = 4'd9;
  localparam logic [3:0] ST_MLC  = 4'd10;
  localparam logic [3:0] ST_SCC  = 4'd11;
  localparam logic [3:0] ST_EMIT = 4'd12;

  logic [3:0] state_q;
  logic [3:0] state_d;

  assign in_stall_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = ST_DT;
        end
      end
      ST_DT: begin
        cmd_o.dt = 1'b1;
        state_d  = sts_i.drop ? ST_IDLE : ST_MUL1;
      end
      ST_MUL1: begin
        cmd_o.mul1 = 1'b1;
        state_d    = ST_MUL2;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_SLEW;
      end
      ST_SLEW: begin
        if (sts_i.is_poll) begin
          cmd_o.calc_ang = 1'b1;
          state_d        = ST_LKS;
        end else begin
          cmd_o.upd_angle = 1'b1;
          state_d         = ST_ANG;
        end
      end
      ST_ANG: begin
        cmd_o.calc_ang  = 1'b1;
        cmd_o.zero_step = 1'b1;
        state_d         = ST_LKS;
      end
      ST_LKS: begin
        cmd_o.look = 1'b1;
        state_d    = ST_MLS;
      end
      ST_MLS: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_SCS;
      end
      ST_SCS: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_LKC;
      end
      ST_LKC: begin
        cmd_o.look    = 1'b1;
        cmd_o.use_cos = 1'b1;
        state_d       = ST_MLC;
      end
      ST_MLC: begin
        cmd_o.mult = 1'b1;
        state_d    = ST_SCC;
      end
      ST_SCC: begin
        cmd_o.scale   = 1'b1;
        cmd_o.use_cos = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.is_poll && sts_i.unchanged) begin
          state_d = ST_IDLE;
        end else if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: rtl/bts_dpath.sv
// ----------------------------------------------------------------------------
// bts_dpath
// Datapath: config registers, button state, angle slew, trig lookup, scaling
// and the output word register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bts_dpath (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  bts_pkg::bts_cmd_t                  cmd_i,
  output bts_pkg::bts_sts_t                  sts_o,
  input  logic                               cfg_we_i,
  input  logic [bts_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [bts_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                               command_i,
  input  logic [2:0]                         button_i,
  input  logic                               pressed_i,
  input  logic                               inverted_i,
  input  logic                               toggle_mode_i,
  input  logic [31:0]                        now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic signed [15:0]                 x_pos_o,
  output logic signed [15:0]                 y_pos_o
);

  localparam logic [29:0] DIV1000_MUL  = 30'd549755814;
  localparam logic [30:0] DIV32767_MUL = 31'd1073774594;
  localparam logic signed [23:0] TURN_S = 24'sd65536;
  localparam logic signed [23:0] APER_S = 24'sd9830;
  localparam int TB = bts_pkg::TRIG_TABLE_BITS;
  localparam int KW = bts_pkg::TRIG_KW;

  function automatic logic ahead_fn(input logic signed [23:0] o, input logic signed [23:0] n);
    logic signed [23:0] top;
    logic signed [23:0] ow;
    top = n + APER_S;
    ow  = o + TURN_S;
    return (o > n && o <= top) || (ow > n && ow <= top);
  endfunction

  function automatic logic behind_fn(input logic signed [23:0] o, input logic signed [23:0] n);
    logic signed [23:0] bot;
    logic signed [23:0] ow;
    bot = n - APER_S;
    ow  = o - TURN_S;
    return (o >= bot && o < n) || (ow >= bot && ow < n);
  endfunction

  function automatic logic [15:0] slew_fn(input logic [15:0] a, input logic [15:0] goal,
                                          input logic [19:0] step);
    logic signed [23:0] av;
    logic signed [23:0] gv;
    logic signed [23:0] sv;
    logic signed [23:0] nv;
    logic [15:0]        res;
    av  = signed'({8'd0, a});
    gv  = signed'({8'd0, goal});
    sv  = signed'({4'd0, step});
    res = goal;
    nv  = av;
    if (ahead_fn(av, gv)) begin
      nv = av - sv;
      if (nv < 0) begin
        nv = nv + TURN_S;
      end
      if (ahead_fn(nv, gv)) begin
        res = nv[15:0];
      end
    end else if (behind_fn(av, gv)) begin
      nv = av + sv;
      if (nv >= TURN_S) begin
        nv = nv - TURN_S;
      end
      if (behind_fn(nv, gv)) begin
        res = nv[15:0];
      end
    end
    return res;
  endfunction

  // bit0 up, bit1 down, bit2 left, bit3 right
  function automatic logic [3:0] cancel_fn(input logic [3:0] h);
    logic [3:0] c;
    c = h;
    if (h[3] && h[2]) begin
      c[3] = 1'b0;
      c[2] = 1'b0;
    end
    if (h[0] && h[1]) begin
      c[0] = 1'b0;
      c[1] = 1'b0;
    end
    return c;
  endfunction

  function automatic logic [15:0] goal_fn(input logic [3:0] c, input logic [15:0] old);
    logic        u;
    logic        d;
    logic        l;
    logic        r;
    logic [15:0] g;
    u = c[0];
    d = c[1];
    l = c[2];
    r = c[3];
    g = old;
    if (r && !u && !d) g = 16'd0;
    if (r && u && !d)  g = 16'd8192;
    if (u && !l && !r) g = 16'd16384;
    if (l && u && !d)  g = 16'd24576;
    if (l && !u && !d) g = 16'd32768;
    if (l && !u && d)  g = 16'd40960;
    if (d && !l && !r) g = 16'd49152;
    if (r && !u && d)  g = 16'd57344;
    return g;
  endfunction

  // config
  logic [14:0] mod_scale_q, mod_scale_d;
  logic [19:0] slew_rate_q, slew_rate_d;
  logic        analog_q, analog_d;
  // block state
  logic [3:0]  held_q, held_d;
  logic        mod_active_q, mod_active_d;
  logic        mod_locked_q, mod_locked_d;
  logic [15:0] cur_q, cur_d;
  logic [15:0] tgt_q, tgt_d;
  logic [14:0] amp_q, amp_d;
  logic [31:0] last_ev_q, last_ev_d;
  logic signed [15:0] last_x_q, last_x_d;
  logic signed [15:0] last_y_q, last_y_d;
  logic        out_valid_q, out_valid_d;
  // working registers
  logic        command_q, command_d;
  logic [2:0]  button_q, button_d;
  logic        pressed_q, pressed_d;
  logic        inverted_q, inverted_d;
  logic        toggle_q, toggle_d;
  logic [31:0] now_q, now_d;
  logic [8:0]  dt_q, dt_d;
  logic        snap_q, snap_d;
  logic [28:0] p1_q, p1_d;
  logic [19:0] step_q, step_d;
  logic [15:0] ang_q, ang_d;
  logic [14:0] trig_q, trig_d;
  logic        neg_q, neg_d;
  logic [29:0] prod_q, prod_d;
  logic signed [15:0] x_q, x_d;
  logic signed [15:0] y_q, y_d;

  // combinational helpers
  logic [3:0]    held_nx;
  logic          act_nx;
  logic          lock_nx;
  logic          level;
  logic [14:0]   amp_nx;
  logic [31:0]   elapsed;
  logic [58:0]   p2;
  logic [60:0]   q2;
  logic [14:0]   qmag;
  logic [TB-1:0] tidx;
  logic [TB-3:0] tr;
  logic [KW-1:0] tk;
  logic          drop;

  assign drop = (command_q == bts_pkg::CMD_EVENT) && (button_q > bts_pkg::BTN_MOD);

  always_comb begin
    held_nx = held_q;
    act_nx  = mod_active_q;
    lock_nx = mod_locked_q;
    level   = pressed_q ^ inverted_q;
    if (button_q < bts_pkg::BTN_MOD) begin
      held_nx[button_q[1:0]] = pressed_q;
    end else if (button_q == bts_pkg::BTN_MOD) begin
      if (!toggle_q) begin
        lock_nx = 1'b0;
        act_nx  = level;
      end else if (level && !mod_locked_q) begin
        lock_nx = 1'b1;
        act_nx  = ~mod_active_q;
      end else if (!level && mod_locked_q) begin
        lock_nx = 1'b0;
      end
    end
    if (|cancel_fn(held_nx)) begin
      amp_nx = act_nx ? mod_scale_q : bts_pkg::FULL_AMP;
    end else begin
      amp_nx = '0;
    end
  end

  assign elapsed = now_q - last_ev_q;
  assign p2      = 59'(p1_q) * 59'(DIV1000_MUL);
  assign q2      = 61'(prod_q) * 61'(DIV32767_MUL);
  assign qmag    = q2[59:45];

  always_comb begin
    tidx = ang_q[15 -: TB] + (cmd_i.use_cos ? TB'(bts_pkg::TRIG_QTR) : '0);
    tr   = tidx[TB-3:0];
    if (tidx[TB-2]) begin
      tk = KW'(bts_pkg::TRIG_QTR) - {1'b0, tr};
    end else begin
      tk = {1'b0, tr};
    end
  end

  always_comb begin
    mod_scale_d  = mod_scale_q;
    slew_rate_d  = slew_rate_q;
    analog_d     = analog_q;
    held_d       = held_q;
    mod_active_d = mod_active_q;
    mod_locked_d = mod_locked_q;
    cur_d        = cur_q;
    tgt_d        = tgt_q;
    amp_d        = amp_q;
    last_ev_d    = last_ev_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    out_valid_d  = cmd_i.emit | (out_valid_q & out_stall_i);
    command_d    = command_q;
    button_d     = button_q;
    pressed_d    = pressed_q;
    inverted_d   = inverted_q;
    toggle_d     = toggle_q;
    now_d        = now_q;
    dt_d         = dt_q;
    snap_d       = snap_q;
    p1_d         = p1_q;
    step_d       = step_q;
    ang_d        = ang_q;
    trig_d       = trig_q;
    neg_d        = neg_q;
    prod_d       = prod_q;
    x_d          = x_q;
    y_d          = y_q;

    if (cfg_we_i) begin
      case (cfg_index_i)
        bts_pkg::REG_MOD_SCALE: mod_scale_d = cfg_data_i[14:0];
        bts_pkg::REG_SLEW_RATE: slew_rate_d = cfg_data_i[19:0];
        bts_pkg::REG_ANALOG:    analog_d    = cfg_data_i[0];
        default: begin
        end
      endcase
    end

    if (cmd_i.latch) begin
      command_d  = command_i;
      button_d   = button_i;
      pressed_d  = pressed_i;
      inverted_d = inverted_i;
      toggle_d   = toggle_mode_i;
      now_d      = now_ms_i;
    end

    if (cmd_i.dt) begin
      snap_d = (elapsed < bts_pkg::SNAP_MS);
      dt_d   = (elapsed > bts_pkg::MAX_DT_MS) ? bts_pkg::MAX_DT_MS[8:0] : elapsed[8:0];
      if (command_q == bts_pkg::CMD_EVENT && !drop) begin
        held_d       = held_nx;
        mod_active_d = act_nx;
        mod_locked_d = lock_nx;
        amp_d        = amp_nx;
      end
    end

    if (cmd_i.mul1) begin
      p1_d = 29'(slew_rate_q) * 29'(dt_q);
    end

    if (cmd_i.mul2) begin
      step_d = p2[58:39];
    end

    if (cmd_i.upd_angle) begin
      tgt_d     = goal_fn(cancel_fn(held_q), tgt_q);
      cur_d     = snap_q ? goal_fn(cancel_fn(held_q), tgt_q) : slew_fn(cur_q, tgt_q, step_q);
      last_ev_d = now_q;
    end

    if (cmd_i.calc_ang) begin
      ang_d = analog_q ? slew_fn(cur_q, tgt_q, cmd_i.zero_step ? '0 : step_q) : tgt_q;
    end

    if (cmd_i.look) begin
      trig_d = bts_pkg::QSIN_TAB[tk];
      neg_d  = tidx[TB-1];
    end

    if (cmd_i.mult) begin
      prod_d = 30'(amp_q) * 30'(trig_q);
    end

    if (cmd_i.scale) begin
      if (cmd_i.use_cos) begin
        x_d = neg_q ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
      end else begin
        y_d = neg_q ? -signed'({1'b0, qmag}) : signed'({1'b0, qmag});
      end
    end

    if (cmd_i.emit) begin
      last_x_d = x_q;
      last_y_d = y_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mod_scale_q  <= bts_pkg::RST_MOD_SCALE;
      slew_rate_q  <= bts_pkg::RST_SLEW_RATE;
      analog_q     <= 1'b0;
      held_q       <= '0;
      mod_active_q <= 1'b0;
      mod_locked_q <= 1'b0;
      cur_q        <= '0;
      tgt_q        <= '0;
      amp_q        <= '0;
      last_ev_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      mod_scale_q  <= mod_scale_d;
      slew_rate_q  <= slew_rate_d;
      analog_q     <= analog_d;
      held_q       <= held_d;
      mod_active_q <= mod_active_d;
      mod_locked_q <= mod_locked_d;
      cur_q        <= cur_d;
      tgt_q        <= tgt_d;
      amp_q        <= amp_d;
      last_ev_q    <= last_ev_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    command_q  <= command_d;
    button_q   <= button_d;
    pressed_q  <= pressed_d;
    inverted_q <= inverted_d;
    toggle_q   <= toggle_d;
    now_q      <= now_d;
    dt_q       <= dt_d;
    snap_q     <= snap_d;
    p1_q       <= p1_d;
    step_q     <= step_d;
    ang_q      <= ang_d;
    trig_q     <= trig_d;
    neg_q      <= neg_d;
    prod_q     <= prod_d;
    x_q        <= x_d;
    y_q        <= y_d;
  end

  assign sts_o.is_poll   = (command_q == bts_pkg::CMD_POLL);
  assign sts_o.drop      = drop;
  assign sts_o.unchanged = (x_q == last_x_q) && (y_q == last_y_q);
  assign sts_o.out_free  = !out_valid_q || !out_stall_i;

  // the output word register is the last reported position
  assign out_valid_o = out_valid_q;
  assign x_pos_o     = last_x_q;
  assign y_pos_o     = last_y_q;

endmodule

// File: rtl/buttons_to_analog_stick.sv
// ----------------------------------------------------------------------------
// buttons_to_analog_stick
// Four direction buttons plus a modifier turned into a Q15 stick position.
//
// Each input word is handled on its own. A button event passes the elapsed
// time, rate and slew states, then the angle, sine and cosine states, and
// loads its result word once the output register is free; a poll skips the
// angle update and gives no word if it finds the position unchanged. A button
// event with a code above 4 is dropped in the elapsed-time state. No new word
// is taken until the sequencer is back in idle. The work is a sequence of
// registered multiplies (rate times time, divide by 1000, amplitude times trig,
// divide by 32767), with one shared sine table read twice, for y then x.
// in_stall_o is low only while the sequencer is idle. A finished word waits in
// the output register while the next input word is taken. Configuration writes
// are always ready and must be issued only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buttons_to_analog_stick (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           command_i,
  input  logic [2:0]                     button_i,
  input  logic                           pressed_i,
  input  logic                           inverted_i,
  input  logic                           toggle_mode_i,
  input  logic [31:0]                    now_ms_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic signed [15:0]             x_pos_o,
  output logic signed [15:0]             y_pos_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  bts_pkg::bts_cmd_t dp_cmd;
  bts_pkg::bts_sts_t dp_sts;

  assign cfg_ready_o = 1'b1;

  bts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (dp_sts),
    .cmd_o      (dp_cmd)
  );

  bts_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (dp_cmd),
    .sts_o         (dp_sts),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .command_i     (command_i),
    .button_i      (button_i),
    .pressed_i     (pressed_i),
    .inverted_i    (inverted_i),
    .toggle_mode_i (toggle_mode_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o)
  );

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted word did not start the sequencer");

  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dp_cmd.emit |-> (!out_valid_o || !out_stall_i))
    else $error("output word overwritten while pending");

  a_rise_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(dp_cmd.emit))
    else $error("output valid rose without an emit");

  a_xy_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (x_pos_o != 16'sh8000) && (y_pos_o != 16'sh8000))
    else $error("position outside Q15 range");

endmodule

// File: test/buttons_to_analog_stick_tb.sv
// ----------------------------------------------------------------------------
// buttons_to_analog_stick_tb
// Self-checking bench for the button-to-stick converter. A short scripted
// sequence (reset state, the four cardinal directions, cancellation, modifier
// levels, toggle latching, bad button codes, time wrap) is followed by random
// phases under different register settings. An in-bench stick model predicts
// every position word; output words are checked in order, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module buttons_to_analog_stick_tb;

  localparam int CYCLE_LIMIT   = 500000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASES        = 6;
  localparam int PHASE_WORDS   = 100;

  localparam logic       CMD_EVENT = bts_pkg::CMD_EVENT;
  localparam logic       CMD_POLL  = bts_pkg::CMD_POLL;
  localparam logic [2:0] BTN_MOD   = bts_pkg::BTN_MOD;

  localparam logic [2:0] BTN_UP      = 3'd0;
  localparam logic [2:0] BTN_DOWN    = 3'd1;
  localparam logic [2:0] BTN_LEFT    = 3'd2;
  localparam logic [2:0] BTN_RIGHT   = 3'd3;
  localparam logic [2:0] BTN_JUNK_LO = 3'd5;
  localparam logic [2:0] BTN_JUNK_HI = 3'd7;

  localparam logic [15:0] ANG_E  = 16'd0;
  localparam logic [15:0] ANG_NE = 16'd8192;
  localparam logic [15:0] ANG_N  = 16'd16384;
  localparam logic [15:0] ANG_NW = 16'd24576;
  localparam logic [15:0] ANG_W  = 16'd32768;
  localparam logic [15:0] ANG_SW = 16'd40960;
  localparam logic [15:0] ANG_S  = 16'd49152;
  localparam logic [15:0] ANG_SE = 16'd57344;

  localparam longint TURN_UNITS = 65536;
  localparam longint WINDOW     = 9830;
  localparam longint MS_PER_S   = 1000;
  localparam longint Q15_ONE    = 32767;
  localparam longint Q30_ONE    = 64'sd1073741824;
  localparam int     LUT_N      = 1 << bts_pkg::TRIG_TABLE_BITS;
  localparam int     LUT_QTR    = LUT_N / 4;

  typedef struct packed {
    logic        cmd;
    logic [2:0]  btn;
    logic        pressed;
    logic        inv;
    logic        tog;
    logic [31:0] now;
  } stick_word_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
  } stick_pos_t;

  typedef struct packed {
    stick_word_t w;
    logic        typed;
    logic        emits;
    stick_pos_t  pos;
  } stim_row_t;

  localparam stim_row_t SCRIPT [0:23] = '{
    '{'{CMD_POLL,  BTN_UP,      1'b0, 1'b0, 1'b0, 32'd0},   1'b1, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_JUNK_LO, 1'b1, 1'b0, 1'b0, 32'd5},   1'b1, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_JUNK_HI, 1'b1, 1'b1, 1'b1, 32'd6},   1'b1, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_RIGHT,   1'b1, 1'b0, 1'b0, 32'd20},  1'b1, 1'b1, '{16'sd32766, 16'sd0}},
    '{'{CMD_EVENT, BTN_RIGHT,   1'b0, 1'b0, 1'b0, 32'd40},  1'b1, 1'b1, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_UP,      1'b1, 1'b0, 1'b0, 32'd60},  1'b1, 1'b1, '{16'sd0, 16'sd32766}},
    '{'{CMD_EVENT, BTN_DOWN,    1'b1, 1'b0, 1'b0, 32'd80},  1'b1, 1'b1, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_UP,      1'b0, 1'b0, 1'b0, 32'd100}, 1'b1, 1'b1, '{16'sd0, -16'sd32766}},
    '{'{CMD_EVENT, BTN_LEFT,    1'b1, 1'b0, 1'b0, 32'd120}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_DOWN,    1'b0, 1'b0, 1'b0, 32'd140}, 1'b1, 1'b1, '{-16'sd32766, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b1, 1'b0, 1'b0, 32'd160}, 1'b1, 1'b1, '{-16'sd16384, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b0, 1'b0, 1'b0, 32'd180}, 1'b1, 1'b1, '{-16'sd32766, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b0, 1'b1, 1'b0, 32'd200}, 1'b1, 1'b1, '{-16'sd16384, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b1, 1'b0, 1'b1, 32'd203}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b1, 1'b0, 1'b1, 32'd205}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b0, 1'b0, 1'b1, 32'd207}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_MOD,     1'b1, 1'b0, 1'b1, 32'd209}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_RIGHT,   1'b1, 1'b0, 1'b0, 32'd230}, 1'b1, 1'b1, '{16'sd0, 16'sd0}},
    '{'{CMD_POLL,  BTN_JUNK_HI, 1'b1, 1'b1, 1'b1, 32'd240}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_LEFT,    1'b0, 1'b0, 1'b0, 32'd260}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_UP,      1'b1, 1'b0, 1'b0, 32'd280}, 1'b0, 1'b0, '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_RIGHT,   1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF}, 1'b0, 1'b0,
      '{16'sd0, 16'sd0}},
    '{'{CMD_POLL,  BTN_MOD,     1'b0, 1'b0, 1'b0, 32'h0000_0003}, 1'b0, 1'b0,
      '{16'sd0, 16'sd0}},
    '{'{CMD_EVENT, BTN_JUNK_LO, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFF0}, 1'b1, 1'b0,
      '{16'sd0, 16'sd0}}
  };

  logic                           clk_i;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic                           command_i     = CMD_EVENT;
  logic [2:0]                     button_i      = 3'd0;
  logic                           pressed_i     = 1'b0;
  logic                           inverted_i    = 1'b0;
  logic                           toggle_mode_i = 1'b0;
  logic [31:0]                    now_ms_i      = 32'd0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic signed [15:0]             x_pos_o;
  logic signed [15:0]             y_pos_o;
  logic                           cfg_valid_i   = 1'b0;
  logic                           cfg_ready_o;
  logic [bts_pkg::CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [bts_pkg::CFG_DATA_W-1:0] cfg_data_i    = '0;

  buttons_to_analog_stick dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .command_i     (command_i),
    .button_i      (button_i),
    .pressed_i     (pressed_i),
    .inverted_i    (inverted_i),
    .toggle_mode_i (toggle_mode_i),
    .now_ms_i      (now_ms_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .x_pos_o       (x_pos_o),
    .y_pos_o       (y_pos_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // stick model state
  logic [14:0] cfg_scale;
  logic [19:0] cfg_rate;
  logic        cfg_emu;
  logic [3:0]  dir_held;
  logic        mod_on;
  logic        mod_latch;
  logic [15:0] cur_ang;
  logic [15:0] goal_ang;
  logic [14:0] amp;
  logic [31:0] last_ms;
  stick_pos_t  prev_pos;
  longint      qsin_lut [0:LUT_QTR];

  stick_pos_t  pos_expected [$];
  int          mismatches  = 0;
  int          cycle_count = 0;
  int          stall_tick  = 0;
  int          burst_left  = 0;

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic longint poly_qsin(int k);
    longint z;
    longint z2;
    longint p;
    longint s;
    z  = (longint'(k) << (16 - bts_pkg::TRIG_TABLE_BITS)) * 64'sd65536;
    z2 = z * z / Q30_ONE;
    p  = -64'sd3864;
    p  = 64'sd172272 + p * z2 / Q30_ONE;
    p  = -64'sd5026997 + p * z2 / Q30_ONE;
    p  = 64'sd85569306 + p * z2 / Q30_ONE;
    p  = -64'sd693598669 + p * z2 / Q30_ONE;
    p  = 64'sd1686629713 + p * z2 / Q30_ONE;
    s  = p * z / Q30_ONE;
    if (s < 0) s = 0;
    if (s > Q30_ONE) s = Q30_ONE;
    return (s * Q15_ONE + Q30_ONE / 2) / Q30_ONE;
  endfunction

  function automatic longint wave_sine(int unsigned i);
    int unsigned r;
    i = i & (LUT_N - 1);
    r = i & (LUT_QTR - 1);
    case (i / LUT_QTR)
      0: return qsin_lut[r];
      1: return qsin_lut[LUT_QTR - r];
      2: return -qsin_lut[r];
      default: return -qsin_lut[LUT_QTR - r];
    endcase
  endfunction

  function automatic logic near_above(longint o, longint n);
    return (o > n && o <= n + WINDOW) ||
           (o + TURN_UNITS > n && o + TURN_UNITS <= n + WINDOW);
  endfunction

  function automatic logic near_below(longint o, longint n);
    return (o >= n - WINDOW && o < n) ||
           (o - TURN_UNITS >= n - WINDOW && o - TURN_UNITS < n);
  endfunction

  function automatic logic [15:0] slew_angle(logic [31:0] now);
    logic [31:0] dt;
    longint      a;
    longint      g;
    longint      stride;
    dt = now - last_ms;
    if (dt > bts_pkg::MAX_DT_MS) dt = bts_pkg::MAX_DT_MS;
    stride = longint'(cfg_rate) * longint'(dt) / MS_PER_S;
    a = longint'(cur_ang);
    g = longint'(goal_ang);
    if (near_above(a, g)) begin
      a -= stride;
      if (a < 0) a += TURN_UNITS;
      if (!near_above(a, g)) return goal_ang;
    end else if (near_below(a, g)) begin
      a += stride;
      if (a >= TURN_UNITS) a -= TURN_UNITS;
      if (!near_below(a, g)) return goal_ang;
    end else begin
      return goal_ang;
    end
    return a[15:0];
  endfunction

  function automatic void aim_goal(logic r, logic l, logic u, logic d);
    if (r && !u && !d) goal_ang = ANG_E;
    if (r && u && !d)  goal_ang = ANG_NE;
    if (u && !l && !r) goal_ang = ANG_N;
    if (l && u && !d)  goal_ang = ANG_NW;
    if (l && !u && !d) goal_ang = ANG_W;
    if (l && !u && d)  goal_ang = ANG_SW;
    if (d && !l && !r) goal_ang = ANG_S;
    if (r && !u && d)  goal_ang = ANG_SE;
  endfunction

  function automatic stick_pos_t stick_at(logic [31:0] now);
    logic [15:0] ang;
    int unsigned idx;
    longint      px;
    longint      py;
    stick_pos_t  p;
    ang = cfg_emu ? slew_angle(now) : goal_ang;
    idx = {16'd0, ang} >> (16 - bts_pkg::TRIG_TABLE_BITS);
    px  = longint'(amp) * wave_sine(idx + LUT_QTR) / Q15_ONE;
    py  = longint'(amp) * wave_sine(idx) / Q15_ONE;
    p.x = px[15:0];
    p.y = py[15:0];
    return p;
  endfunction

  function automatic logic predict_stick(input stick_word_t w, output stick_pos_t p);
    logic        r;
    logic        l;
    logic        u;
    logic        d;
    logic        lvl;
    logic [31:0] gap;
    if (w.cmd == CMD_POLL) begin
      p = stick_at(w.now);
      if (p == prev_pos) return 1'b0;
    end else begin
      if (w.btn > BTN_MOD) return 1'b0;
      if (w.btn < BTN_MOD) begin
        dir_held[w.btn[1:0]] = w.pressed;
      end else begin
        lvl = w.pressed ^ w.inv;
        if (!w.tog) begin
          mod_latch = 1'b0;
          mod_on    = lvl;
        end else if (lvl && !mod_latch) begin
          mod_latch = 1'b1;
          mod_on    = !mod_on;
        end else if (!lvl && mod_latch) begin
          mod_latch = 1'b0;
        end
      end
      u = dir_held[BTN_UP];
      d = dir_held[BTN_DOWN];
      l = dir_held[BTN_LEFT];
      r = dir_held[BTN_RIGHT];
      if (r && l) begin
        r = 1'b0;
        l = 1'b0;
      end
      if (u && d) begin
        u = 1'b0;
        d = 1'b0;
      end
      amp = (r || l || u || d) ? (mod_on ? cfg_scale : bts_pkg::FULL_AMP) : 15'd0;
      gap = w.now - last_ms;
      if (gap < bts_pkg::SNAP_MS) begin
        aim_goal(r, l, u, d);
        cur_ang = goal_ang;
      end else begin
        cur_ang = slew_angle(w.now);
        aim_goal(r, l, u, d);
      end
      last_ms = w.now;
      p = stick_at(w.now);
    end
    prev_pos = p;
    return 1'b1;
  endfunction

  task automatic send_word(input stick_word_t w, input logic typed, input logic typed_emits,
                           input stick_pos_t typed_pos);
    stick_pos_t p;
    logic       emits;
    in_valid_i    <= 1'b1;
    command_i     <= w.cmd;
    button_i      <= w.btn;
    pressed_i     <= w.pressed;
    inverted_i    <= w.inv;
    toggle_mode_i <= w.tog;
    now_ms_i      <= w.now;
    do @(posedge clk_i); while (in_stall_o);
    emits = predict_stick(w, p);
    if (typed) begin
      emits = typed_emits;
      p     = typed_pos;
    end
    if (emits) pos_expected.push_back(p);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? int'($urandom_range(20, 60))
                                                : int'($urandom_range(0, 8));
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pos_expected.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_regs(input logic [14:0] sc, input logic [19:0] rt, input logic em);
    logic [bts_pkg::CFG_IDX_W-1:0]  idx [0:2];
    logic [bts_pkg::CFG_DATA_W-1:0] val [0:2];
    idx[0] = bts_pkg::REG_MOD_SCALE;
    idx[1] = bts_pkg::REG_SLEW_RATE;
    idx[2] = bts_pkg::REG_ANALOG;
    val[0] = bts_pkg::CFG_DATA_W'(sc);
    val[1] = rt;
    val[2] = bts_pkg::CFG_DATA_W'(em);
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[i];
      cfg_data_i  <= val[i];
      do @(posedge clk_i); while (!cfg_ready_o);
    end
    cfg_valid_i <= 1'b0;
    cfg_scale = sc;
    cfg_rate  = rt;
    cfg_emu   = em;
  endtask

  // receiver stall: none, light, heavy, then long on/off runs
  always @(posedge clk_i) begin
    stall_tick <= stall_tick + 1;
    case (stall_tick[9:8])
      2'd0:    out_stall_i <= 1'b0;
      2'd1:    out_stall_i <= ($urandom_range(0, 9) < 3);
      2'd2:    out_stall_i <= ($urandom_range(0, 9) < 8);
      default: out_stall_i <= stall_tick[4];
    endcase
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("buttons_to_analog_stick_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk_i) begin : check_words
    stick_pos_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pos_expected.size() == 0) begin
        $error("unexpected word: x_pos %0d y_pos %0d", x_pos_o, y_pos_o);
        mismatches++;
      end else begin
        want = pos_expected.pop_front();
        if (x_pos_o !== want.x) begin
          $error("x_pos: expected %0d, got %0d", want.x, x_pos_o);
          mismatches++;
        end
        if (y_pos_o !== want.y) begin
          $error("y_pos: expected %0d, got %0d", want.y, y_pos_o);
          mismatches++;
        end
      end
    end
  end

  initial begin
    stick_word_t w;
    logic [31:0] ms_clock;
    logic [14:0] sc;
    logic [19:0] rt;
    logic        em;
    int          sent;
    int          pick;

    for (int k = 0; k <= LUT_QTR; k++) qsin_lut[k] = poly_qsin(k);
    cfg_scale = bts_pkg::RST_MOD_SCALE;
    cfg_rate  = bts_pkg::RST_SLEW_RATE;
    cfg_emu   = 1'b0;
    dir_held  = '0;
    mod_on    = 1'b0;
    mod_latch = 1'b0;
    cur_ang   = '0;
    goal_ang  = '0;
    amp       = '0;
    last_ms   = '0;
    prev_pos  = '0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < $size(SCRIPT); i++) begin
      send_word(SCRIPT[i].w, SCRIPT[i].typed, SCRIPT[i].emits, SCRIPT[i].pos);
      pace();
    end

    ms_clock = 32'd1000;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_idle();
      case (ph)
        0: begin
          sc = 15'h7FFF;
          rt = bts_pkg::RST_SLEW_RATE;
          em = 1'b1;
        end
        1: begin
          sc = 15'd0;
          rt = 20'hFFFFF;
          em = 1'b1;
        end
        2: begin
          sc = 15'($urandom_range(1, 32766));
          rt = 20'd0;
          em = 1'b1;
        end
        3: begin
          sc = 15'($urandom_range(0, 32767));
          rt = 20'($urandom_range(0, 20'hFFFFF));
          em = 1'b0;
        end
        4: begin
          sc = 15'($urandom_range(0, 32767));
          rt = 20'($urandom_range(1000, 200000));
          em = 1'b1;
        end
        default: begin
          sc = bts_pkg::RST_MOD_SCALE;
          rt = 20'($urandom_range(0, 20'hFFFFF));
          em = 1'b1;
        end
      endcase
      write_regs(sc, rt, em);

      sent = 0;
      while (sent < PHASE_WORDS) begin
        pick = $urandom_range(0, 99);
        if (pick < 12)      ms_clock += $urandom_range(0, 9);
        else if (pick < 70) ms_clock += $urandom_range(10, 40);
        else if (pick < 94) ms_clock += $urandom_range(41, 700);
        else                ms_clock = $urandom();
        w         = '0;
        w.now     = ms_clock;
        w.pressed = 1'($urandom_range(0, 1));
        w.inv     = ($urandom_range(0, 3) == 0);
        w.tog     = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          w.cmd = CMD_POLL;
          w.btn = 3'($urandom_range(0, 7));
        end else begin
          w.cmd = CMD_EVENT;
          if (pick < 86)      w.btn = 3'($urandom_range(BTN_UP, BTN_RIGHT));
          else if (pick < 96) w.btn = BTN_MOD;
          else                w.btn = 3'($urandom_range(BTN_JUNK_LO, BTN_JUNK_HI));
        end
        send_word(w, 1'b0, 1'b0, '0);
        if (!(w.cmd == CMD_EVENT && w.btn > BTN_MOD)) sent++;
        pace();
      end
    end

    wait_idle();
    if (mismatches == 0) begin
      $display("buttons_to_analog_stick_tb: PASS");
    end else begin
      $display("buttons_to_analog_stick_tb: FAIL");
    end
    $finish;
  end

endmodule

// File: buttons_to_analog_stick.f
rtl/bts_pkg.sv
rtl/bts_ctrl.sv
rtl/bts_dpath.sv
rtl/buttons_to_analog_stick.sv
test/buttons_to_analog_stick_tb.sv
